// File: hdl/assert_macros.svh
// assertion macros for the route table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: hdl/dvrt_pkg.sv
// shared types, codes and constants of the route table
package dvrt_pkg;

  localparam int ADDR_W = 32;
  localparam int COST_W = 17;
  localparam int STAT_W = 3;
  localparam int CHG_W  = 5;

  localparam logic [COST_W-1:0] COST_INF = 17'd99999;
  localparam logic [CHG_W-1:0]  CHG_MAX  = 5'd31;

  localparam int DEF_TABLE_DEPTH  = 16;
  localparam int DEF_ADVERT_DEPTH = 16;

  typedef enum logic [1:0] {
    KIND_LINK   = 2'd0,
    KIND_ADVERT = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_FULL     = 3'd1,
    ST_REJECTED = 3'd2,
    ST_UNKNOWN  = 3'd3,
    ST_NO_ROUTE = 3'd4,
    ST_LOCAL    = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    KEY_A,
    KEY_B,
    KEY_ADV
  } key_sel_t;

  typedef enum logic [1:0] {
    OUT_PLAIN,
    OUT_LOCAL,
    OUT_ROUTE,
    OUT_COMMIT
  } out_kind_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_NB_UPD,
    WR_NB_APP,
    WR_REM_APP,
    WR_RELAX
  } wr_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LK_START,
    S_LK_WAIT,
    S_LU_START,
    S_LU_WAIT,
    S_LU_READ,
    S_ADV_PUSH,
    S_CM_CHK,
    S_CM_SND,
    S_CM_NB,
    S_CM_ENT,
    S_CM_ENT2,
    S_CM_RWAIT,
    S_CM_RCMP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic      latch;
    logic      srch_start;
    key_sel_t  key_sel;
    logic      row_rd;
    logic      nb_latch;
    wr_op_t    wr_op;
    logic      adv_push;
    logic      adv_clear;
    logic      adv_rd;
    logic      e_clr;
    logic      e_inc;
    logic      out_load;
    status_t   out_status;
    out_kind_t out_kind;
  } dvrt_cmd_t;

  typedef struct packed {
    logic srch_done;
    logic found;
    logic is_nb;
    logic tbl_full;
    logic a_own;
    logic b_own;
    logic last;
    logic rej;
    logic ovf;
    logic e_end;
    logic adv_own;
    logic better;
  } dvrt_stat_t;

endpackage

// File: hdl/dvrt_ctrl.sv
// sequencer for link, advertisement and lookup items, and the commit after the last advertisement entry
module dvrt_ctrl
  import dvrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] kind,
  output logic       in_stall,
  input  logic       out_stall,
  output logic       out_valid,
  output dvrt_cmd_t  cmd,
  input  dvrt_stat_t stat
);

  state_t    state, state_next;
  logic      out_vld, out_vld_next;
  logic      second, second_next;
  logic      fail, fail_next;
  status_t   res_status, res_status_next;
  out_kind_t res_kind, res_kind_next;
  logic      nbmode;
  logic      slot_free;

  assign nbmode    = stat.a_own || stat.b_own;
  assign slot_free = !out_vld || !out_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_valid = out_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      out_vld <= 1'b0;
    end else begin
      state   <= state_next;
      out_vld <= out_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    second     <= second_next;
    fail       <= fail_next;
    res_status <= res_status_next;
    res_kind   <= res_kind_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (kind_t'(kind))
            KIND_LINK:   state_next = S_LK_START;
            KIND_ADVERT: state_next = S_ADV_PUSH;
            KIND_LOOKUP: state_next = S_LU_START;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_LK_START: state_next = S_LK_WAIT;
      S_LK_WAIT: begin
        if (stat.srch_done) begin
          state_next = (!nbmode && !second) ? S_LK_START : S_FINISH;
        end
      end
      S_LU_START: state_next = stat.b_own ? S_FINISH : S_LU_WAIT;
      S_LU_WAIT: begin
        if (stat.srch_done) begin
          state_next = stat.found ? S_LU_READ : S_FINISH;
        end
      end
      S_LU_READ:  state_next = S_FINISH;
      S_ADV_PUSH: state_next = stat.last ? S_CM_CHK : S_IDLE;
      S_CM_CHK:   state_next = (stat.rej || stat.ovf) ? S_FINISH : S_CM_SND;
      S_CM_SND: begin
        if (stat.srch_done) begin
          state_next = stat.found ? S_CM_NB : S_FINISH;
        end
      end
      S_CM_NB:   state_next = S_CM_ENT;
      S_CM_ENT:  state_next = stat.e_end ? S_FINISH : S_CM_ENT2;
      S_CM_ENT2: state_next = stat.adv_own ? S_CM_ENT : S_CM_RWAIT;
      S_CM_RWAIT: begin
        if (stat.srch_done) begin
          state_next = (stat.found && !stat.is_nb) ? S_CM_RCMP : S_CM_ENT;
        end
      end
      S_CM_RCMP: state_next = S_CM_ENT;
      S_FINISH: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    second_next     = second;
    fail_next       = fail;
    res_status_next = res_status;
    res_kind_next   = res_kind;
    out_vld_next    = out_vld && out_stall;
    cmd.latch       = (state == S_IDLE) && in_valid;
    if (cmd.latch) begin
      second_next = 1'b0;
      fail_next   = 1'b0;
    end
    unique case (state)
      S_IDLE: ;
      S_LK_START: begin
        cmd.srch_start = 1'b1;
        if (nbmode) begin
          cmd.key_sel = stat.a_own ? KEY_B : KEY_A;
        end else begin
          cmd.key_sel = second ? KEY_B : KEY_A;
        end
      end
      S_LK_WAIT: begin
        if (stat.srch_done) begin
          if (stat.found) begin
            if (nbmode) begin
              cmd.wr_op = WR_NB_UPD;
            end
          end else if (stat.tbl_full) begin
            fail_next = 1'b1;
          end else begin
            cmd.wr_op = nbmode ? WR_NB_APP : WR_REM_APP;
          end
          if (!nbmode && !second) begin
            second_next = 1'b1;
          end
          res_status_next = (fail || (!stat.found && stat.tbl_full)) ? ST_FULL : ST_DONE;
          res_kind_next   = OUT_PLAIN;
        end
      end
      S_LU_START: begin
        if (stat.b_own) begin
          res_status_next = ST_LOCAL;
          res_kind_next   = OUT_LOCAL;
        end else begin
          cmd.srch_start = 1'b1;
          cmd.key_sel    = KEY_B;
        end
      end
      S_LU_WAIT: begin
        if (stat.srch_done) begin
          if (stat.found) begin
            cmd.row_rd = 1'b1;
          end else begin
            res_status_next = ST_NO_ROUTE;
            res_kind_next   = OUT_PLAIN;
          end
        end
      end
      S_LU_READ: begin
        res_status_next = ST_DONE;
        res_kind_next   = OUT_ROUTE;
      end
      S_ADV_PUSH: cmd.adv_push = 1'b1;
      S_CM_CHK: begin
        if (stat.rej) begin
          cmd.adv_clear   = 1'b1;
          res_status_next = ST_REJECTED;
          res_kind_next   = OUT_PLAIN;
        end else if (stat.ovf) begin
          cmd.adv_clear   = 1'b1;
          res_status_next = ST_OVERFLOW;
          res_kind_next   = OUT_PLAIN;
        end else begin
          cmd.srch_start = 1'b1;
          cmd.key_sel    = KEY_A;
        end
      end
      S_CM_SND: begin
        if (stat.srch_done) begin
          if (stat.found) begin
            cmd.row_rd = 1'b1;
          end else begin
            cmd.adv_clear   = 1'b1;
            res_status_next = ST_UNKNOWN;
            res_kind_next   = OUT_PLAIN;
          end
        end
      end
      S_CM_NB: begin
        cmd.nb_latch = 1'b1;
        cmd.e_clr    = 1'b1;
      end
      S_CM_ENT: begin
        if (stat.e_end) begin
          cmd.adv_clear   = 1'b1;
          res_status_next = ST_DONE;
          res_kind_next   = OUT_COMMIT;
        end else begin
          cmd.adv_rd = 1'b1;
        end
      end
      S_CM_ENT2: begin
        if (stat.adv_own) begin
          cmd.e_inc = 1'b1;
        end else begin
          cmd.srch_start = 1'b1;
          cmd.key_sel    = KEY_ADV;
        end
      end
      S_CM_RWAIT: begin
        if (stat.srch_done) begin
          if (stat.found && !stat.is_nb) begin
            cmd.row_rd = 1'b1;
          end else begin
            cmd.e_inc = 1'b1;
          end
        end
      end
      S_CM_RCMP: begin
        if (stat.better) begin
          cmd.wr_op = WR_RELAX;
        end
        cmd.e_inc = 1'b1;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = res_status;
          cmd.out_kind   = res_kind;
          out_vld_next   = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/dvrt_dp.sv
// route table, advertisement buffer, search unit and result registers
module dvrt_dp
  import dvrt_pkg::*;
#(
  parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
  parameter int ADVERT_DEPTH = DEF_ADVERT_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [ADDR_W-1:0] cfg_data,
  input  logic [ADDR_W-1:0] first_address,
  input  logic [ADDR_W-1:0] second_address,
  input  logic [COST_W-1:0] link_cost,
  input  logic              last_entry,
  input  dvrt_cmd_t         cmd,
  output dvrt_stat_t        stat,
  output logic [STAT_W-1:0] status,
  output logic [ADDR_W-1:0] next_hop,
  output logic              next_hop_known,
  output logic [COST_W-1:0] route_cost,
  output logic [CHG_W-1:0]  changed_count
);

  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int AIW = $clog2(ADVERT_DEPTH);
  localparam int ACW = $clog2(ADVERT_DEPTH + 1);

  logic [ADDR_W-1:0] dest_mem [TABLE_DEPTH];
  logic [ADDR_W-1:0] hop_mem  [TABLE_DEPTH];
  logic              known_mem[TABLE_DEPTH];
  logic [COST_W-1:0] cost_mem [TABLE_DEPTH];
  logic [ADDR_W-1:0] adv_dest_mem[ADVERT_DEPTH];
  logic [COST_W-1:0] adv_cost_mem[ADVERT_DEPTH];

  logic [ADDR_W-1:0] own_address;
  logic [ADDR_W-1:0] it_a, it_b;
  logic [COST_W-1:0] it_cost;
  logic              it_last;

  logic [CW-1:0]     route_count;
  logic [ACW-1:0]    adv_count;
  logic [ACW-1:0]    adv_idx;
  logic              rej, ovf;

  logic              s_busy, s_pend, srch_done;
  logic [CW-1:0]     s_idx;
  logic [IW-1:0]     s_pidx;
  logic [ADDR_W-1:0] s_key;
  logic [ADDR_W-1:0] rd_dest;
  logic              s_more, s_hit;
  logic              found;
  logic [IW-1:0]     fidx;

  logic [ADDR_W-1:0] rd_hop;
  logic              rd_known;
  logic [COST_W-1:0] rd_cost;
  logic [ADDR_W-1:0] nb_hop;
  logic              nb_known;
  logic [COST_W-1:0] nb_cost;
  logic [IW-1:0]     nb_idx;
  logic [ADDR_W-1:0] ad_dest;
  logic [COST_W-1:0] ad_cost;

  logic [TABLE_DEPTH-1:0] impr;
  logic [CHG_W-1:0]       chg;

  logic [COST_W:0]   through_sum;
  logic [COST_W-1:0] through;

  logic              wr_en, wr_app;
  logic [IW-1:0]     wr_addr;
  logic [ADDR_W-1:0] wr_hop;
  logic              wr_known;
  logic [COST_W-1:0] wr_cost;
  logic [ADDR_W-1:0] key_mux;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (cfg_write) begin
      own_address <= cfg_data;
    end
  end

  // item capture with cost clamped to infinity
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      it_a    <= first_address;
      it_b    <= second_address;
      it_cost <= (link_cost > COST_INF) ? COST_INF : link_cost;
      it_last <= last_entry;
    end
  end

  // linear search over the occupied rows
  assign s_more = (s_idx < route_count);
  assign s_hit  = s_pend && (rd_dest == s_key);

  always_comb begin
    case (cmd.key_sel)
      KEY_A:   key_mux = it_a;
      KEY_B:   key_mux = it_b;
      default: key_mux = ad_dest;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_busy    <= 1'b0;
      s_pend    <= 1'b0;
      srch_done <= 1'b0;
    end else begin
      srch_done <= 1'b0;
      if (cmd.srch_start) begin
        s_busy <= 1'b1;
        s_pend <= 1'b0;
        s_idx  <= '0;
        s_key  <= key_mux;
      end else if (s_busy) begin
        if (s_hit) begin
          s_busy    <= 1'b0;
          s_pend    <= 1'b0;
          srch_done <= 1'b1;
          found     <= 1'b1;
          fidx      <= s_pidx;
        end else if (s_more) begin
          s_pend <= 1'b1;
          s_pidx <= s_idx[IW-1:0];
          s_idx  <= CW'(s_idx + 1'b1);
        end else if (s_pend) begin
          s_pend <= 1'b0;
        end else begin
          s_busy    <= 1'b0;
          srch_done <= 1'b1;
          found     <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_busy && s_more && !s_hit) begin
      rd_dest <= dest_mem[s_idx[IW-1:0]];
    end
  end

  // row read, sender capture and advertisement entry read
  always_ff @(posedge clk) begin
    if (cmd.row_rd) begin
      rd_hop   <= hop_mem[fidx];
      rd_known <= known_mem[fidx];
      rd_cost  <= cost_mem[fidx];
    end
    if (cmd.nb_latch) begin
      nb_hop   <= rd_hop;
      nb_known <= rd_known;
      nb_cost  <= rd_cost;
      nb_idx   <= fidx;
    end
    if (cmd.adv_rd) begin
      ad_dest <= adv_dest_mem[adv_idx[AIW-1:0]];
      ad_cost <= adv_cost_mem[adv_idx[AIW-1:0]];
    end
  end

  assign through_sum = {1'b0, nb_cost} + {1'b0, ad_cost};
  assign through     = (through_sum > {1'b0, COST_INF}) ? COST_INF : through_sum[COST_W-1:0];

  // route table write port
  always_comb begin
    wr_en    = 1'b1;
    wr_app   = 1'b0;
    wr_hop   = s_key;
    wr_known = 1'b1;
    wr_cost  = it_cost;
    unique case (cmd.wr_op)
      WR_NONE:   wr_en = 1'b0;
      WR_NB_UPD: ;
      WR_NB_APP: wr_app = 1'b1;
      WR_REM_APP: begin
        wr_app   = 1'b1;
        wr_hop   = '0;
        wr_known = 1'b0;
        wr_cost  = COST_INF;
      end
      WR_RELAX: begin
        wr_hop   = nb_hop;
        wr_known = nb_known;
        wr_cost  = through;
      end
      default: wr_en = 1'b0;
    endcase
    wr_addr = wr_app ? route_count[IW-1:0] : fidx;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dest_mem[wr_addr]  <= s_key;
      hop_mem[wr_addr]   <= wr_hop;
      known_mem[wr_addr] <= wr_known;
      cost_mem[wr_addr]  <= wr_cost;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      route_count <= '0;
    end else if (wr_en && wr_app) begin
      route_count <= CW'(route_count + 1'b1);
    end
  end

  // improvement count over distinct rows
  always_ff @(posedge clk) begin
    if (cmd.nb_latch) begin
      impr <= '0;
      chg  <= '0;
    end else if (cmd.wr_op == WR_RELAX && !impr[fidx]) begin
      impr[fidx] <= 1'b1;
      if (chg != CHG_MAX) begin
        chg <= CHG_W'(chg + 1'b1);
      end
    end
  end

  // advertisement buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      adv_count <= '0;
      rej       <= 1'b0;
      ovf       <= 1'b0;
    end else if (cmd.adv_clear) begin
      adv_count <= '0;
      rej       <= 1'b0;
      ovf       <= 1'b0;
    end else if (cmd.adv_push) begin
      if (it_a == it_b) begin
        rej <= 1'b1;
      end
      if (adv_count < ACW'(ADVERT_DEPTH)) begin
        adv_count <= ACW'(adv_count + 1'b1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.adv_push && adv_count < ACW'(ADVERT_DEPTH)) begin
      adv_dest_mem[adv_count[AIW-1:0]] <= it_b;
      adv_cost_mem[adv_count[AIW-1:0]] <= it_cost;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.e_clr) begin
      adv_idx <= '0;
    end else if (cmd.e_inc) begin
      adv_idx <= ACW'(adv_idx + 1'b1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status         <= cmd.out_status;
      next_hop       <= '0;
      next_hop_known <= 1'b0;
      route_cost     <= '0;
      changed_count  <= '0;
      case (cmd.out_kind)
        OUT_LOCAL: begin
          next_hop       <= own_address;
          next_hop_known <= 1'b1;
        end
        OUT_ROUTE: begin
          next_hop       <= rd_known ? rd_hop : '0;
          next_hop_known <= rd_known;
          route_cost     <= rd_cost;
        end
        OUT_COMMIT: changed_count <= chg;
        default: ;
      endcase
    end
  end

  always_comb begin
    stat           = '0;
    stat.srch_done = srch_done;
    stat.found     = found;
    stat.is_nb     = (fidx == nb_idx);
    stat.tbl_full  = (route_count == CW'(TABLE_DEPTH));
    stat.a_own     = (it_a == own_address);
    stat.b_own     = (it_b == own_address);
    stat.last      = it_last;
    stat.rej       = rej;
    stat.ovf       = ovf;
    stat.e_end     = (adv_idx == adv_count);
    stat.adv_own   = (ad_dest == own_address);
    stat.better    = (through < rd_cost);
  end

endmodule

// File: hdl/distance_vector_route_table.sv
// a lookup searches the table and reads the row it finds; a link item searches for its ends
// a plain advert entry is only buffered; the last one commits the buffer, searching the sender and each entry
// rate is set by the search unit reading one route row per cycle from the table, while the output is not stalled
// one item at a time; the next item is taken while a result waits to be taken
// synchronous reset clears counts, flags, own address and handshake; tables unset
`include "assert_macros.svh"
module distance_vector_route_table
  import dvrt_pkg::*;
#(
  parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
  parameter int ADVERT_DEPTH = DEF_ADVERT_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [ADDR_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        kind,
  input  logic [ADDR_W-1:0] first_address,
  input  logic [ADDR_W-1:0] second_address,
  input  logic [COST_W-1:0] link_cost,
  input  logic              last_entry,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] status,
  output logic [ADDR_W-1:0] next_hop,
  output logic              next_hop_known,
  output logic [COST_W-1:0] route_cost,
  output logic [CHG_W-1:0]  changed_count
);

  dvrt_cmd_t  cmd;
  dvrt_stat_t stat;

  dvrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .kind      (kind),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  dvrt_dp #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .ADVERT_DEPTH (ADVERT_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .first_address  (first_address),
    .second_address (second_address),
    .link_cost      (link_cost),
    .last_entry     (last_entry),
    .cmd            (cmd),
    .stat           (stat),
    .status         (status),
    .next_hop       (next_hop),
    .next_hop_known (next_hop_known),
    .route_cost     (route_cost),
    .changed_count  (changed_count)
  );

  `ASSERT_IMPLIES(a_search_busy, clk, rst, stat.srch_done, in_stall, "search ended while idle")
  `ASSERT_IMPLIES(a_write_busy, clk, rst, cmd.wr_op != WR_NONE, in_stall, "table write while idle")
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst, cmd.out_load, !out_valid || !out_stall, "result lost")
  `ASSERT_NEXT(a_load_shown, clk, rst, cmd.out_load, out_valid, "loaded result not shown")

endmodule
